[hw/rtl/atp_pkg.sv]
`timescale 1ns / 1ps
package atp_pkg;

  localparam int unsigned MAX_TASKS_DEF   = 1024;
  localparam int unsigned MAX_WORKERS_DEF = 16;
  localparam int unsigned MAX_PREDS_DEF   = 16;

  localparam int ID_W   = 10;
  localparam int PREF_W = 6;
  localparam int WC_W   = 5;
  localparam int LEN_W  = 11;
  localparam int EDGE_W = 20;
  localparam int SPAN_W = 4;
  localparam int CWO_W  = 4;

  localparam logic [LEN_W-1:0]  LEN_SAT  = '1;
  localparam logic [EDGE_W-1:0] EDGE_SAT = '1;
  localparam logic [SPAN_W-1:0] SPAN_SAT = '1;

  localparam logic [WC_W-1:0]  WC_RESET = WC_W'(16);
  localparam logic [LEN_W-1:0] QL_RESET = LEN_W'(64);

  localparam logic FUNC_PRED  = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PREF = 2'd1,
    ST_ALL_FULL = 2'd2,
    ST_UNPLACED = 2'd3
  } status_e;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   id;
    logic [PREF_W-1:0] pref;
  } item_t;

  typedef struct packed {
    logic [WC_W-1:0]  worker_count;
    logic [LEN_W-1:0] queue_limit;
  } cfg_t;

endpackage

[hw/rtl/atp_if.sv]
`timescale 1ns / 1ps
interface atp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [atp_pkg::ID_W-1:0]   pred_task;
  logic [atp_pkg::ID_W-1:0]   task_id;
  logic [atp_pkg::PREF_W-1:0] pref_worker;
  modport source (output valid, func, pred_task, task_id, pref_worker, input ready);
  modport sink   (input valid, func, pred_task, task_id, pref_worker, output ready);
endinterface

interface atp_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [atp_pkg::CWO_W-1:0]  chosen_worker;
  logic [atp_pkg::LEN_W-1:0]  longest_queue;
  logic [atp_pkg::EDGE_W-1:0] local_edges;
  logic [atp_pkg::SPAN_W-1:0] peak_span;
  logic [atp_pkg::LEN_W-1:0]  unfenced_producers;
  modport source (output valid, status, chosen_worker, longest_queue, local_edges,
                  peak_span, unfenced_producers, input ready);
  modport sink   (input valid, status, chosen_worker, longest_queue, local_edges,
                  peak_span, unfenced_producers, output ready);
endinterface

[hw/rtl/affinity_balanced_task_placer_unit.sv]
`timescale 1ns / 1ps
// Greedy affinity task placer. Feed each task's placed producers as predecessor requests
// (func 0), then one place request (func 1); every request yields one result with status and
// running statistics. A predecessor request does one lookup in the placement memory and,
// if the producer is placed and the pending list has room, one affinity update. A place
// request runs a selection scan over the W workers in use, W being the number of workers
// in use, then takes two steps per pending producer, one to read its placement and flags
// and one to update its flags and the statistics. After reset the block sweeps the
// placement and flag memories before it takes its first request;
// configuration writes are taken at any time. A two-entry queue holds requests while the
// engine works, and an output register holds a result until the sink takes it. MAX_TASKS
// must be a power of two.
module affinity_balanced_task_placer_unit #(
  parameter int unsigned MAX_TASKS   = atp_pkg::MAX_TASKS_DEF,
  parameter int unsigned MAX_WORKERS = atp_pkg::MAX_WORKERS_DEF,
  parameter int unsigned MAX_PREDS   = atp_pkg::MAX_PREDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atp_in_if.sink      req_i,
  atp_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atp_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_ready;

  // register map: worker_count at 0x0, queue_limit at 0x4
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(cfg_q.queue_limit) : 32'(cfg_q.worker_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.worker_count <= WC_RESET;
      cfg_q.queue_limit  <= QL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        cfg_q.queue_limit <= pwdata[LEN_W-1:0];
      end else begin
        cfg_q.worker_count <= pwdata[WC_W-1:0];
      end
    end
  end

  // front: take requests and keep the relevant id
  atp_front u_front (
    .clk_i, .rst_ni, .req_i,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  // back: lookup, selection scan and statistics
  atp_back #(
    .MAX_TASKS(MAX_TASKS), .MAX_WORKERS(MAX_WORKERS), .MAX_PREDS(MAX_PREDS)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_i(item), .item_valid_i(item_valid), .item_ready_o(item_ready),
    .res_o
  );
endmodule

[hw/rtl/atp_ram.sv]
`timescale 1ns / 1ps
module atp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/atp_front.sv]
`timescale 1ns / 1ps
module atp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  atp_in_if.sink          req_i,
  output atp_pkg::item_t  item_o,
  output logic            item_valid_o,
  input  logic            item_ready_i
);
  import atp_pkg::*;

  item_t      buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item_in;

  // classify: keep only the id that the request's function uses
  always_comb begin
    item_in.func = req_i.func;
    item_in.id   = (req_i.func == FUNC_PLACE) ? req_i.task_id : req_i.pred_task;
    item_in.pref = req_i.pref_worker;
  end

  assign req_i.ready  = (cnt_q != 2'd2);
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        buf_q[wr_ptr_q] <= item_in;
        wr_ptr_q        <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

[hw/rtl/atp_back.sv]
`timescale 1ns / 1ps
module atp_back #(
  parameter int unsigned MAX_TASKS   = atp_pkg::MAX_TASKS_DEF,
  parameter int unsigned MAX_WORKERS = atp_pkg::MAX_WORKERS_DEF,
  parameter int unsigned MAX_PREDS   = atp_pkg::MAX_PREDS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  atp_pkg::cfg_t  cfg_i,
  input  atp_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  atp_out_if.source      res_o
);
  import atp_pkg::*;

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NWC = $clog2(MAX_WORKERS + 1);
  localparam int PW  = (MAX_PREDS > 1) ? $clog2(MAX_PREDS) : 1;
  localparam int PCW = $clog2(MAX_PREDS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PRD, S_AINC, S_SCAN, S_DECIDE, S_QINC, S_KPEND, S_KUPD, S_DONE
  } state_e;

  state_e            state_q;
  logic [TW-1:0]     clr_q;
  item_t             cur_q;
  logic [LEN_W-1:0]  aff_q [MAX_WORKERS];
  logic [LEN_W-1:0]  ql_q  [MAX_WORKERS];
  logic [WW-1:0]     idx_q, best_q;
  logic              best_vld_q;
  logic [LEN_W-1:0]  best_aff_q, best_ql_q;
  logic [PCW-1:0]    pcnt_q, k_q;
  logic [TW-1:0]     p_q;
  logic [EDGE_W-1:0] edge_q;
  logic [SPAN_W-1:0] span_q;
  logic [LEN_W-1:0]  ffc_q, long_q;
  status_e           rstat_q;
  logic [CWO_W-1:0]  rcw_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [CWO_W-1:0]  out_cw_q;
  logic [LEN_W-1:0]  out_long_q, out_ffc_q;
  logic [EDGE_W-1:0] out_edge_q;
  logic [SPAN_W-1:0] out_span_q;

  // placement memory: {placed, worker}; flag memory: {all local, successor seen}
  logic              pl_we, fl_we, pd_we;
  logic [TW-1:0]     pl_waddr, pl_raddr, fl_raddr;
  logic [WW:0]       pl_wdata, pl_rdata;
  logic [1:0]        fl_wdata, fl_rdata;
  logic [PW-1:0]     pd_waddr, pd_raddr;
  logic [TW-1:0]     pd_rdata;

  logic [NWC-1:0]    nwk;
  logic [TW-1:0]     tidx;
  logic [LEN_W-1:0]  a_w, q_w, nq;
  logic              take;
  logic [WW-1:0]     pw;
  logic              same, was_free, now_free;
  logic [1:0]        nf;
  int                span_d;
  logic              load_out;

  atp_ram #(.WIDTH(WW + 1), .DEPTH(MAX_TASKS)) u_place_ram (
    .clk_i, .we_i(pl_we), .waddr_i(pl_waddr), .wdata_i(pl_wdata),
    .raddr_i(pl_raddr), .rdata_o(pl_rdata)
  );
  atp_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_flag_ram (
    .clk_i, .we_i(fl_we), .waddr_i(pl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );
  atp_ram #(.WIDTH(TW), .DEPTH(MAX_PREDS)) u_pend_ram (
    .clk_i, .we_i(pd_we), .waddr_i(pd_waddr), .wdata_i(tidx),
    .raddr_i(pd_raddr), .rdata_o(pd_rdata)
  );

  always_comb begin
    if (cfg_i.worker_count == '0) begin
      nwk = NWC'(1);
    end else if (int'(cfg_i.worker_count) > int'(MAX_WORKERS)) begin
      nwk = NWC'(MAX_WORKERS);
    end else begin
      nwk = NWC'(cfg_i.worker_count);
    end
  end

  assign tidx         = TW'(cur_q.id);
  assign item_ready_o = (state_q == S_IDLE);
  assign a_w          = aff_q[idx_q];
  assign q_w          = ql_q[idx_q];
  assign nq           = (q_w == LEN_SAT) ? q_w : q_w + 1'b1;
  assign take = (q_w < cfg_i.queue_limit) &&
                (!best_vld_q || (a_w > best_aff_q) ||
                 ((a_w == best_aff_q) && ((q_w < best_ql_q) ||
                  ((q_w == best_ql_q) && (int'(idx_q) == int'(cur_q.pref))))));

  // producer statistics for one pending edge
  assign pw       = pl_rdata[WW-1:0];
  assign same     = (pw == best_q);
  assign was_free = (fl_rdata == 2'b11);
  always_comb begin
    if (!fl_rdata[0]) begin
      nf = same ? 2'b11 : 2'b01;
    end else if (!same) begin
      nf = 2'b01;
    end else begin
      nf = fl_rdata;
    end
  end
  assign now_free = (nf == 2'b11);
  assign span_d   = int'(pw) - int'(best_q);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    pl_we    = 1'b0;
    fl_we    = 1'b0;
    pd_we    = 1'b0;
    pl_waddr = p_q;
    pl_wdata = '0;
    fl_wdata = nf;
    pl_raddr = TW'(item_i.id);
    fl_raddr = pd_rdata;
    pd_waddr = PW'(pcnt_q);
    pd_raddr = PW'(k_q + 1'b1);
    unique case (state_q)
      S_CLR: begin
        pl_we    = 1'b1;
        fl_we    = 1'b1;
        pl_waddr = clr_q;
        fl_wdata = 2'b00;
      end
      S_PRD: pd_we = pl_rdata[WW] && (int'(pcnt_q) < int'(MAX_PREDS));
      S_DECIDE: begin
        pl_we    = best_vld_q;
        pl_waddr = tidx;
        pl_wdata = {1'b1, best_q};
      end
      S_QINC:  pd_raddr = '0;
      S_KPEND: pl_raddr = pd_rdata;
      S_KUPD:  fl_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      cur_q        <= '0;
      aff_q        <= '{default: '0};
      ql_q         <= '{default: '0};
      idx_q        <= '0;
      best_q       <= '0;
      best_vld_q   <= 1'b0;
      best_aff_q   <= '0;
      best_ql_q    <= '0;
      pcnt_q       <= '0;
      k_q          <= '0;
      p_q          <= '0;
      edge_q       <= '0;
      span_q       <= '0;
      ffc_q        <= '0;
      long_q       <= '0;
      rstat_q      <= ST_OK;
      rcw_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_cw_q     <= '0;
      out_long_q   <= '0;
      out_edge_q   <= '0;
      out_span_q   <= '0;
      out_ffc_q    <= '0;
    end else begin
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == TW'(MAX_TASKS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid_i) begin
            cur_q <= item_i;
            rcw_q <= '0;
            if (item_i.func == FUNC_PRED) begin
              state_q <= S_PRD;
            end else if (int'(item_i.pref) >= int'(nwk)) begin
              rstat_q <= ST_BAD_PREF;
              aff_q   <= '{default: '0};
              pcnt_q  <= '0;
              state_q <= S_DONE;
            end else begin
              idx_q      <= '0;
              best_vld_q <= 1'b0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_PRD: begin
          rstat_q <= pl_rdata[WW] ? ST_OK : ST_UNPLACED;
          if (pl_rdata[WW] && (int'(pcnt_q) < int'(MAX_PREDS))) begin
            pcnt_q  <= pcnt_q + 1'b1;
            idx_q   <= pw;
            state_q <= S_AINC;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_AINC: begin
          if (a_w != LEN_SAT) aff_q[idx_q] <= a_w + 1'b1;
          state_q <= S_DONE;
        end
        S_SCAN: begin
          if (take) begin
            best_vld_q <= 1'b1;
            best_q     <= idx_q;
            best_aff_q <= a_w;
            best_ql_q  <= q_w;
          end
          if (int'(idx_q) == int'(nwk) - 1) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DECIDE: begin
          if (!best_vld_q) begin
            rstat_q <= ST_ALL_FULL;
            aff_q   <= '{default: '0};
            pcnt_q  <= '0;
            state_q <= S_DONE;
          end else begin
            idx_q   <= best_q;
            state_q <= S_QINC;
          end
        end
        S_QINC: begin
          ql_q[idx_q] <= nq;
          if (nq > long_q) long_q <= nq;
          k_q     <= '0;
          rstat_q <= ST_OK;
          rcw_q   <= CWO_W'(best_q);
          if (pcnt_q == '0) begin
            aff_q   <= '{default: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_KPEND;
          end
        end
        S_KPEND: begin
          p_q     <= pd_rdata;
          state_q <= S_KUPD;
        end
        S_KUPD: begin
          if (same && (edge_q != EDGE_SAT)) edge_q <= edge_q + 1'b1;
          if (span_d > int'(span_q)) begin
            span_q <= (span_d > int'(SPAN_SAT)) ? SPAN_SAT : SPAN_W'(span_d);
          end
          if (now_free && !was_free && (ffc_q != LEN_SAT)) ffc_q <= ffc_q + 1'b1;
          if (!now_free && was_free && (ffc_q != '0)) ffc_q <= ffc_q - 1'b1;
          k_q <= k_q + 1'b1;
          if (PCW'(k_q + 1'b1) == pcnt_q) begin
            aff_q   <= '{default: '0};
            pcnt_q  <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_KPEND;
          end
        end
        S_DONE: begin
          if (load_out) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      if (load_out) begin
        out_valid_q  <= 1'b1;
        out_status_q <= rstat_q;
        out_cw_q     <= rcw_q;
        out_long_q   <= long_q;
        out_edge_q   <= edge_q;
        out_span_q   <= span_q;
        out_ffc_q    <= ffc_q;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.status             = out_status_q;
  assign res_o.chosen_worker      = out_cw_q;
  assign res_o.longest_queue      = out_long_q;
  assign res_o.local_edges        = out_edge_q;
  assign res_o.peak_span          = out_span_q;
  assign res_o.unfenced_producers = out_ffc_q;
endmodule

[hw/rtl/atp_checker.sv]
`timescale 1ns / 1ps
module atp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic [atp_pkg::CWO_W-1:0]  chosen_worker,
  input logic [atp_pkg::LEN_W-1:0]  longest_queue
);
  import atp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_fail_worker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != ST_OK) |-> chosen_worker == '0)
    else $error("worker reported on a failed request");

  a_longest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && $past(out_valid) |-> longest_queue >= $past(longest_queue))
    else $error("longest queue fell");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result during reset");
endmodule

bind affinity_balanced_task_placer_unit atp_checker u_atp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(res_o.valid), .out_ready(res_o.ready),
  .status(res_o.status), .chosen_worker(res_o.chosen_worker),
  .longest_queue(res_o.longest_queue)
);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import atp_pkg::*;

  typedef struct {
    status_e          status;
    logic [CWO_W-1:0]  worker;
    logic [LEN_W-1:0]  longest;
    logic [EDGE_W-1:0] edges;
    logic [SPAN_W-1:0] span;
    logic [LEN_W-1:0]  fence_free;
  } placement_t;

  localparam int TASKS   = 1024;
  localparam int WORKERS = 16;
  localparam int PREDS   = 16;
  localparam int REG_WORKER_COUNT = 0;
  localparam int REG_QUEUE_LIMIT  = 1;
  localparam int DRAIN_CYCLES = 150;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  atp_in_if  req_bus ();
  atp_out_if res_bus ();

  affinity_balanced_task_placer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus.sink),
    .res_o   (res_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the placer state, updated for every accepted request.
  int unsigned model_workers = WC_RESET;
  int unsigned model_limit   = QL_RESET;
  bit          task_placed [TASKS];
  int unsigned task_worker [TASKS];
  int unsigned queue_len   [WORKERS];
  int unsigned affinity    [WORKERS];
  logic [1:0]  succ_flags  [TASKS];
  int unsigned pending_ids [PREDS];
  int unsigned pending_n, edge_total, span_peak, fence_total, longest_seen;

  placement_t placement_results_q[$];
  int placed_ids[$];
  int mismatches = 0;
  int requests_sent = 0;

  // Receiver control: long_hold asks the ready process for a long stall.
  bit rx_stalls = 1'b1;
  int long_hold = 0;

  function automatic int unsigned active_workers();
    if (model_workers < 1) return 1;
    if (model_workers > WORKERS) return WORKERS;
    return model_workers;
  endfunction

  function automatic void clear_pending();
    foreach (affinity[w]) affinity[w] = 0;
    pending_n = 0;
  endfunction

  function automatic placement_t predict_placement(logic func, logic [ID_W-1:0] pred,
                                                   logic [ID_W-1:0] tid,
                                                   logic [PREF_W-1:0] pref);
    placement_t r;
    int unsigned workers, p, pw, cw;
    int chosen;
    bit same, was_free, now_free;
    logic [1:0] f;
    workers = active_workers();
    chosen  = -1;
    r.worker = '0;
    r.status = ST_OK;
    if (func == FUNC_PRED) begin
      p = pred;
      if (!task_placed[p]) begin
        r.status = ST_UNPLACED;
      end else if (pending_n < PREDS) begin
        pending_ids[pending_n] = p;
        pending_n++;
        pw = task_worker[p];
        if (affinity[pw] < LEN_SAT) affinity[pw]++;
      end
    end else if (pref >= workers) begin
      clear_pending();
      r.status = ST_BAD_PREF;
    end else begin
      for (int w = 0; w < workers; w++) begin
        if (queue_len[w] >= model_limit) continue;
        if (chosen < 0) begin
          chosen = w;
        end else if (affinity[w] > affinity[chosen] ||
                     (affinity[w] == affinity[chosen] &&
                      (queue_len[w] < queue_len[chosen] ||
                       (queue_len[w] == queue_len[chosen] && w == pref)))) begin
          chosen = w;
        end
      end
      if (chosen < 0) begin
        clear_pending();
        r.status = ST_ALL_FULL;
      end else begin
        cw = chosen;
        task_placed[tid] = 1'b1;
        task_worker[tid] = cw;
        if (queue_len[cw] < LEN_SAT) queue_len[cw]++;
        if (queue_len[cw] > longest_seen) longest_seen = queue_len[cw];
        for (int k = 0; k < pending_n; k++) begin
          p = pending_ids[k];
          pw = task_worker[p];
          same = (pw == cw);
          f = succ_flags[p];
          was_free = (f == 2'b11);
          if (same && edge_total < EDGE_SAT) edge_total++;
          if (pw > cw && pw - cw > span_peak) span_peak = (pw - cw > SPAN_SAT) ? SPAN_SAT : pw - cw;
          if (!f[0]) f = same ? 2'b11 : 2'b01;
          else if (!same) f = 2'b01;
          succ_flags[p] = f;
          now_free = (f == 2'b11);
          if (now_free && !was_free && fence_total < LEN_SAT) fence_total++;
          if (!now_free && was_free && fence_total > 0) fence_total--;
        end
        clear_pending();
        r.worker = CWO_W'(cw);
      end
    end
    r.longest    = LEN_W'(longest_seen);
    r.edges      = EDGE_W'(edge_total);
    r.span       = SPAN_W'(span_peak);
    r.fence_free = LEN_W'(fence_total);
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Receiver: stall at random, mostly briefly, now and then for a long stretch.
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      res_bus.ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (!rx_stalls) begin
      res_bus.ready <= 1'b1;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Sample at the falling edge: the result moves at the next rising edge.
  always @(negedge clk_i) begin
    placement_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (placement_results_q.size() == 0) begin
        flag_mismatch("unexpected result, status", res_bus.status, -1);
      end else begin
        want = placement_results_q.pop_front();
        if (res_bus.status !== want.status) flag_mismatch("status", res_bus.status, want.status);
        if (res_bus.chosen_worker !== want.worker)
          flag_mismatch("chosen_worker", res_bus.chosen_worker, want.worker);
        if (res_bus.longest_queue !== want.longest)
          flag_mismatch("longest_queue", res_bus.longest_queue, want.longest);
        if (res_bus.local_edges !== want.edges)
          flag_mismatch("local_edges", res_bus.local_edges, want.edges);
        if (res_bus.peak_span !== want.span)
          flag_mismatch("peak_span", res_bus.peak_span, want.span);
        if (res_bus.unfenced_producers !== want.fence_free)
          flag_mismatch("unfenced_producers", res_bus.unfenced_producers, want.fence_free);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request; entered and left just after a rising edge. A zero gap
  // leaves valid high so the next request follows back to back.
  task automatic send_request(logic func, logic [ID_W-1:0] pred, logic [ID_W-1:0] tid,
                              logic [PREF_W-1:0] pref, int gap);
    placement_t r;
    req_bus.valid       <= 1'b1;
    req_bus.func        <= func;
    req_bus.pred_task   <= pred;
    req_bus.task_id     <= tid;
    req_bus.pref_worker <= pref;
    forever begin
      @(negedge clk_i);
      if (req_bus.ready) break;
    end
    @(posedge clk_i);
    r = predict_placement(func, pred, tid, pref);
    placement_results_q.insert(placement_results_q.size(), r);
    requests_sent++;
    if (func == FUNC_PLACE && r.status == ST_OK) placed_ids.insert(placed_ids.size(), int'(tid));
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_pred(int id);
    send_request(FUNC_PRED, ID_W'(id), ID_W'($urandom), PREF_W'($urandom), pick_gap());
  endtask

  task automatic send_place(int id, int pref);
    send_request(FUNC_PLACE, ID_W'($urandom), ID_W'(id), PREF_W'(pref), pick_gap());
  endtask

  // Drop valid, wait for every result, then let the engine settle.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (placement_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(int index, int value);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * index);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == REG_WORKER_COUNT) model_workers = value & 31;
    else model_limit = value & 2047;
    @(posedge clk_i);
  endtask

  function automatic int placed_pick();
    if (placed_ids.size() == 0) return $urandom_range(0, TASKS - 1);
    return placed_ids[$urandom_range(0, placed_ids.size() - 1)];
  endfunction

  // Reset defaults: unplaced producer, bad preference, ties, duplicates, list
  // overflow, extreme ids and re-placement.
  task automatic test_directed();
    send_pred(0);
    send_place(0, 63);
    send_place(0, 0);
    send_pred(0);
    send_pred(0);
    send_place(1023, 15);
    send_pred(1023);
    send_pred(0);
    send_place(5, 3);
    repeat (17) send_pred(0);
    send_place(6, 9);
    send_place(0, 7);
  endtask

  task automatic test_worker_counts();
    write_reg(REG_WORKER_COUNT, 1);
    send_pred(5);
    send_place(7, 0);
    send_place(8, 1);
    write_reg(REG_WORKER_COUNT, 0);
    send_place(9, 0);
    send_place(10, 1);
    write_reg(REG_WORKER_COUNT, 31);
    send_pred(9);
    send_place(11, 15);
    send_place(12, 16);
    write_reg(REG_WORKER_COUNT, 17);
    send_place(13, 15);
    write_reg(REG_WORKER_COUNT, 16);
  endtask

  task automatic test_queue_limits();
    write_reg(REG_QUEUE_LIMIT, 0);
    send_pred(0);
    send_place(20, 0);
    write_reg(REG_QUEUE_LIMIT, 1);
    send_place(21, 0);
    send_place(22, 4);
    write_reg(REG_QUEUE_LIMIT, 2047);
    send_place(23, 2);
  endtask

  // Mostly well-formed tasks: placed producers then a place request.
  task automatic test_random(int n_items);
    int target, npred, r, workers;
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      workers = active_workers();
      r = $urandom_range(0, 99);
      npred = (r < 80) ? $urandom_range(0, 6) : (r < 95) ? $urandom_range(7, 16)
                                                          : $urandom_range(17, 20);
      repeat (npred) begin
        if ($urandom_range(0, 9) == 0) send_pred($urandom_range(0, TASKS - 1));
        else send_pred(placed_pick());
      end
      if ($urandom_range(0, 9) == 0) send_place($urandom_range(0, TASKS - 1), $urandom_range(0, 63));
      else send_place($urandom_range(0, TASKS - 1), $urandom_range(0, workers - 1));
    end
  endtask

  // Hold the receiver off long enough to fill the request queue.
  task automatic test_backpressure();
    long_hold = 400;
    repeat (30) send_request(FUNC_PRED, ID_W'(placed_pick()), ID_W'($urandom),
                             PREF_W'($urandom), 0);
    send_request(FUNC_PLACE, ID_W'($urandom), ID_W'($urandom_range(0, TASKS - 1)), '0, 0);
  endtask

  task automatic test_drain_pause();
    rx_stalls = 1'b0;
    test_random(40);
    req_bus.valid <= 1'b0;
    while (placement_results_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    test_random(40);
    rx_stalls = 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.func        = FUNC_PRED;
    req_bus.pred_task   = '0;
    req_bus.task_id     = '0;
    req_bus.pref_worker = '0;
    res_bus.ready       = 1'b0;
    foreach (task_placed[i]) begin
      task_placed[i] = 1'b0;
      task_worker[i] = 0;
      succ_flags[i]  = 2'b00;
    end
    foreach (queue_len[w]) queue_len[w] = 0;
    clear_pending();
    edge_total = 0;
    span_peak = 0;
    fence_total = 0;
    longest_seen = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_worker_counts();
    test_queue_limits();
    write_reg(REG_QUEUE_LIMIT, 1024);
    test_random(500);
    test_backpressure();
    test_drain_pause();
    write_reg(REG_WORKER_COUNT, 5);
    write_reg(REG_QUEUE_LIMIT, 64);
    test_random(250);
    write_reg(REG_WORKER_COUNT, 1);
    write_reg(REG_QUEUE_LIMIT, 1024);
    test_random(150);
    write_reg(REG_WORKER_COUNT, 16);
    write_reg(REG_QUEUE_LIMIT, 2047);
    test_random(350);

    drain();
    if (mismatches == 0 && placement_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/atp_pkg.sv
hw/rtl/atp_if.sv
hw/rtl/atp_ram.sv
hw/rtl/atp_front.sv
hw/rtl/atp_back.sv
hw/rtl/affinity_balanced_task_placer_unit.sv
hw/rtl/atp_checker.sv
tb/tb.sv
